@@ hdl/apph_pkg.sv @@
// Package for the averaged pressure pump controller.
// Holds the request and result types, the inter-stage type, register indexes and
// the fixed-point constants. Has no dependencies.
package apph_pkg;

	localparam int ADC_BITS  = 12;
	localparam int PRESS_W   = 10;
	localparam int SP_W      = 10;
	localparam int BAND_W    = 7;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = SP_W + BAND_W;
	localparam int BOUND_W   = PROD_W + 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_PERCENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESSURE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESSURE = 3'd3;

	localparam logic [SP_W-1:0]   SETPOINT_RST     = 10'd0;
	localparam logic [BAND_W-1:0] BAND_PERCENT_RST = 7'd5;
	localparam logic [SP_W-1:0]   MIN_PRESSURE_RST = 10'd0;
	localparam logic [SP_W-1:0]   MAX_PRESSURE_RST = 10'd0;

	// Opcodes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Pressure = avg * 0.1274 - 0.7057, both constants in Q16.
	localparam int GAIN_W     = 14;
	localparam int CONV_W     = ADC_BITS + GAIN_W;
	localparam int FRAC_BITS  = 16;
	localparam logic [GAIN_W-1:0] GAIN_Q16   = 14'd8349;
	localparam logic [CONV_W-1:0] OFFSET_Q16 = 26'd46249;
	localparam logic [PRESS_W-1:0] PRESS_MAX = 10'd1023;

	localparam logic [BOUND_W-1:0] BAND_DIV  = 18'd100;
	localparam logic [BOUND_W-1:0] BAND_RND  = 18'd99;

	typedef struct packed {
		logic                opcode;
		logic [ADC_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic               pump_on;
		logic [PRESS_W-1:0] pressure;
		logic               pressure_updated;
	} out_item_t;

	typedef struct packed {
		logic                tick;
		logic                done;
		logic [ADC_BITS-1:0] avg;
		logic [PROD_W-1:0]   prod;
	} s2_item_t;

endpackage

@@ hdl/apph_accum.sv @@
// Sample accumulator and averaging stages of the pressure pump controller.
// Sums samples, divides each finished sum by a reciprocal multiply and forms the
// band product. Depends on apph_pkg.
module apph_accum #(
	parameter int SAMPLES_PER_AVERAGE = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  apph_pkg::in_item_t              in_item,
	input  logic [apph_pkg::SP_W-1:0]       setpoint,
	input  logic [apph_pkg::BAND_W-1:0]     band_percent,
	input  logic                            take,
	output logic                            s2_valid,
	output apph_pkg::s2_item_t              s2_item
);

	localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE);
	localparam int SUM_W = apph_pkg::ADC_BITS + CNT_W;
	localparam int SHIFT = SUM_W + CNT_W;
	localparam int M_W   = SUM_W + 1;
	localparam int P_W   = SUM_W + M_W;
	localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(SAMPLES_PER_AVERAGE) - 1)
		/ longint'(SAMPLES_PER_AVERAGE);
	localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_add;
	logic             accept;
	logic             cnt_last;
	logic             move12;

	logic             valid_s1;
	logic             tick_s1;
	logic             done_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [P_W-1:0]   quot_full;

	assign move12   = valid_s1 && (!s2_valid || take);
	assign in_stall = valid_s1 && !move12;
	assign accept   = in_valid && !in_stall;
	assign cnt_last = (cnt_q == CNT_LAST);
	assign sum_add  = sum_q + SUM_W'(in_item.sample);

	// The reciprocal is rounded up with enough fraction bits that the
	// quotient is exact for every reachable sum.
	assign quot_full = P_W'(sum_s1) * P_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (accept && in_item.opcode == apph_pkg::OP_SAMPLE) begin
			if (cnt_last) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_add;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move12) begin
				valid_s1 <= 1'b0;
			end
			if (move12) begin
				s2_valid <= 1'b1;
			end else if (take) begin
				s2_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= (in_item.opcode == apph_pkg::OP_TICK);
			done_s1 <= (in_item.opcode == apph_pkg::OP_SAMPLE) && cnt_last;
			sum_s1  <= sum_add;
		end
		if (move12) begin
			s2_item.tick <= tick_s1;
			s2_item.done <= done_s1;
			s2_item.avg  <= quot_full[SHIFT +: apph_pkg::ADC_BITS];
			s2_item.prod <= apph_pkg::PROD_W'(setpoint) * apph_pkg::PROD_W'(band_percent);
		end
	end

endmodule

@@ hdl/apph_ctrl.sv @@
// Conversion and hysteresis stage of the pressure pump controller.
// Turns an average into pressure, runs the pump decision and holds the result
// register. Depends on apph_pkg.
module apph_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s2_valid,
	input  apph_pkg::s2_item_t            s2_item,
	input  logic [apph_pkg::SP_W-1:0]     setpoint,
	input  logic [apph_pkg::SP_W-1:0]     min_pressure,
	input  logic [apph_pkg::SP_W-1:0]     max_pressure,
	output logic                          take,
	output logic                          out_valid,
	input  logic                          out_stall,
	output apph_pkg::out_item_t           out_item
);

	localparam int CW = apph_pkg::CONV_W;
	localparam int PW = apph_pkg::PRESS_W;
	localparam int BW = apph_pkg::BOUND_W;
	localparam int DW = apph_pkg::SP_W + 1;

	logic [PW-1:0] press_q;
	logic          pump_q;

	logic [CW-1:0] conv_t;
	logic [CW-1:0] conv_d;
	logic [PW-1:0] conv_p;
	logic [PW-1:0] press_next;
	logic          pump_next;

	logic [DW-1:0] diff;
	logic [DW-1:0] mag_full;
	logic [BW-1:0] bound;
	logic          band_ok;
	logic          lo_hit;
	logic          hi_hit;

	assign take = s2_valid && (!out_valid || !out_stall);

	always_comb begin
		conv_t = CW'(s2_item.avg) * CW'(apph_pkg::GAIN_Q16);
		conv_d = conv_t - apph_pkg::OFFSET_Q16;
		if (conv_t <= apph_pkg::OFFSET_Q16) begin
			conv_p = '0;
		end else if (conv_d[CW-1:apph_pkg::FRAC_BITS] > (CW - apph_pkg::FRAC_BITS)'(apph_pkg::PRESS_MAX)) begin
			conv_p = apph_pkg::PRESS_MAX;
		end else begin
			conv_p = PW'(conv_d[CW-1:apph_pkg::FRAC_BITS]);
		end
		press_next = s2_item.done ? conv_p : press_q;
	end

	// The band test floor(prod/100) <= |p - setpoint| is done as
	// prod <= 100*|p - setpoint| + 99, so no division is needed.
	always_comb begin
		diff     = {1'b0, press_q} - {1'b0, setpoint};
		mag_full = diff[DW-1] ? (~diff + DW'(1)) : diff;
		bound    = BW'(mag_full[DW-2:0]) * apph_pkg::BAND_DIV + apph_pkg::BAND_RND;
		band_ok  = BW'(s2_item.prod) <= bound;
		if (setpoint != '0) begin
			lo_hit = (diff[DW-1] || diff == '0) && band_ok;
			hi_hit = !diff[DW-1] && band_ok;
		end else begin
			lo_hit = press_q <= min_pressure;
			hi_hit = press_q >= max_pressure;
		end
		pump_next = pump_q;
		if (s2_item.tick) begin
			if (hi_hit) begin
				pump_next = 1'b0;
			end else if (lo_hit) begin
				pump_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= '0;
			pump_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				press_q   <= press_next;
				pump_q    <= pump_next;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_item.pump_on          <= pump_next;
			out_item.pressure         <= press_next;
			out_item.pressure_updated <= s2_item.done;
		end
	end

	a_press_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(press_q))
		else $error("pressure changed without a request");

	a_tick_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		take && s2_item.tick |=> out_valid && !out_item.pressure_updated)
		else $error("tick request flagged a new average");

	a_sample_pump: assert property (@(posedge clk) disable iff (!arst_n)
		take && !s2_item.tick |=> pump_q == $past(pump_q))
		else $error("sample request moved the pump");

	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_item.pressure == press_q && out_item.pump_on == pump_q)
		else $error("result disagrees with controller state");

endmodule

@@ hdl/averaged_pressure_pump_hysteresis_top.sv @@
// Top level of the averaged pressure pump controller.
// Holds the configuration registers and joins the accumulator and control stages.
// Depends on apph_pkg, apph_accum and apph_ctrl.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_stall   in_item  (opcode, sample)
//   out       result     out_valid / out_stall out_item (pump_on, pressure, pressure_updated)
//   cfg       write      cfg_we               cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; its result is registered by each stage below in turn.
// The pipeline is an input stage, a divide stage (one reciprocal multiply) and the
// result register (gain multiply and band compare).
// Reset clears the averaging state, pressure and pump, and loads register defaults.
// While out_stall is high the result holds; the two inner stages keep taking
// requests until they are full, then in_stall rises.
module averaged_pressure_pump_hysteresis_top #(
	parameter int SAMPLES_PER_AVERAGE = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  apph_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output apph_pkg::out_item_t              out_item,
	input  logic                             cfg_we,
	input  logic [apph_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apph_pkg::CFG_W-1:0]       cfg_data
);

	logic [apph_pkg::SP_W-1:0]   setpoint_q;
	logic [apph_pkg::BAND_W-1:0] band_percent_q;
	logic [apph_pkg::SP_W-1:0]   min_pressure_q;
	logic [apph_pkg::SP_W-1:0]   max_pressure_q;

	logic               take;
	logic               s2_valid;
	apph_pkg::s2_item_t s2_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q     <= apph_pkg::SETPOINT_RST;
			band_percent_q <= apph_pkg::BAND_PERCENT_RST;
			min_pressure_q <= apph_pkg::MIN_PRESSURE_RST;
			max_pressure_q <= apph_pkg::MAX_PRESSURE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				apph_pkg::REG_SETPOINT: begin
					setpoint_q <= cfg_data[apph_pkg::SP_W-1:0];
				end
				apph_pkg::REG_BAND_PERCENT: begin
					band_percent_q <= cfg_data[apph_pkg::BAND_W-1:0];
				end
				apph_pkg::REG_MIN_PRESSURE: begin
					min_pressure_q <= cfg_data[apph_pkg::SP_W-1:0];
				end
				apph_pkg::REG_MAX_PRESSURE: begin
					max_pressure_q <= cfg_data[apph_pkg::SP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	apph_accum #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.setpoint     (setpoint_q),
		.band_percent (band_percent_q),
		.take         (take),
		.s2_valid     (s2_valid),
		.s2_item      (s2_item)
	);

	apph_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s2_valid     (s2_valid),
		.s2_item      (s2_item),
		.setpoint     (setpoint_q),
		.min_pressure (min_pressure_q),
		.max_pressure (max_pressure_q),
		.take         (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item)
	);

endmodule

@@ sim/averaged_pressure_pump_hysteresis_top_test.sv @@
// Testbench for averaged_pressure_pump_hysteresis_top: directed and random requests, checked
// against an in-bench model of the averaging, pressure conversion and pump hysteresis.
// Depends on apph_pkg and the averaged_pressure_pump_hysteresis_top RTL.
module averaged_pressure_pump_hysteresis_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int AVG_LEN = 15;
	localparam int SETTLE_CYCLES = 6;
	localparam longint GAIN = 8349;
	localparam longint OFFSET = 46249;
	localparam int SAMPLE_W = apph_pkg::ADC_BITS;
	localparam int PW = apph_pkg::PRESS_W;
	localparam logic [apph_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	apph_pkg::in_item_t             in_item = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	apph_pkg::out_item_t            out_item;
	logic                           cfg_we = 1'b0;
	logic [apph_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [apph_pkg::CFG_W-1:0]     cfg_data = '0;

	// Model state and register copies, at their reset values.
	logic [3:0]                   avg_count = '0;
	logic [15:0]                  avg_sum = '0;
	logic [apph_pkg::PRESS_W-1:0] last_pressure = '0;
	logic                         pump_flag = 1'b0;
	logic [apph_pkg::SP_W-1:0]    sp_reg = '0;
	logic [apph_pkg::BAND_W-1:0]  band_reg = 7'd5;
	logic [apph_pkg::SP_W-1:0]    min_reg = '0;
	logic [apph_pkg::SP_W-1:0]    max_reg = '0;

	apph_pkg::out_item_t expected_results[$];
	int                  mismatches = 0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  cycles = 0;

	averaged_pressure_pump_hysteresis_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [apph_pkg::PRESS_W-1:0] to_pressure(input logic [15:0] avg);
		longint t;
		t = longint'(avg) * GAIN - OFFSET;
		if (t <= 0)
			return '0;
		if ((t >> 16) > 1023)
			return 10'd1023;
		return PW'(t >> 16);
	endfunction

	function automatic apph_pkg::out_item_t predict_result(input apph_pkg::in_item_t req);
		apph_pkg::out_item_t res;
		int                  lvl, half, lo, hi;
		logic                updated;
		updated = 1'b0;
		if (req.opcode == apph_pkg::OP_SAMPLE) begin
			avg_sum = avg_sum + 16'(req.sample);
			avg_count = avg_count + 4'd1;
			if (avg_count >= AVG_LEN) begin
				last_pressure = to_pressure(16'(avg_sum / AVG_LEN));
				avg_sum = '0;
				avg_count = '0;
				updated = 1'b1;
			end
		end else begin
			lvl = int'(last_pressure);
			if (sp_reg != 0) begin
				half = (int'(sp_reg) * int'(band_reg)) / 100;
				lo = int'(sp_reg) - half;
				hi = int'(sp_reg) + half;
			end else begin
				lo = int'(min_reg);
				hi = int'(max_reg);
			end
			// The off test comes last, so it wins when both limits hold.
			if (lvl <= lo)
				pump_flag = 1'b1;
			if (lvl >= hi)
				pump_flag = 1'b0;
		end
		res.pump_on = pump_flag;
		res.pressure = last_pressure;
		res.pressure_updated = updated;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic check_result(input apph_pkg::out_item_t got);
		apph_pkg::out_item_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result %p with no request pending", got));
			return;
		end
		want = expected_results.pop_front();
		if (got.pump_on !== want.pump_on)
			report_mismatch($sformatf("pump_on %b, expected %b", got.pump_on, want.pump_on));
		if (got.pressure !== want.pressure)
			report_mismatch($sformatf("pressure %0d, expected %0d", got.pressure,
				want.pressure));
		if (got.pressure_updated !== want.pressure_updated)
			report_mismatch($sformatf("pressure_updated %b, expected %b",
				got.pressure_updated, want.pressure_updated));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result(out_item);
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("averaged_pressure_pump_hysteresis_top: mismatch");
			$finish;
		end
	end

	// Called at a rising edge; valid stays high after acceptance so back-to-back
	// requests never lower and raise it in the same step.
	task automatic send_request(input logic op, input logic [apph_pkg::ADC_BITS-1:0] value);
		apph_pkg::in_item_t req;
		req.opcode = op;
		req.sample = value;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_result(req));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [apph_pkg::CFG_IDX_W-1:0] idx,
		input logic [apph_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			apph_pkg::REG_SETPOINT:     sp_reg = data[apph_pkg::SP_W-1:0];
			apph_pkg::REG_BAND_PERCENT: band_reg = data[apph_pkg::BAND_W-1:0];
			apph_pkg::REG_MIN_PRESSURE: min_reg = data[apph_pkg::SP_W-1:0];
			apph_pkg::REG_MAX_PRESSURE: max_reg = data[apph_pkg::SP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_reset_defaults;
		// Defaults put both limits at zero with pressure zero: both hold, pump stays off.
		send_request(apph_pkg::OP_TICK, '1);
	endtask

	task automatic test_full_scale_average;
		for (int i = 0; i < AVG_LEN; i++) begin
			if (i == 7)
				send_request(apph_pkg::OP_TICK, '0);
			send_request(apph_pkg::OP_SAMPLE, '1);
		end
	endtask

	task automatic test_plain_limits;
		drain;
		write_reg(apph_pkg::REG_SETPOINT, '0);
		write_reg(apph_pkg::REG_MIN_PRESSURE, 10'd600);
		write_reg(apph_pkg::REG_MAX_PRESSURE, 10'd1023);
		send_request(apph_pkg::OP_TICK, 12'h5a5);
		drain;
		write_reg(apph_pkg::REG_MIN_PRESSURE, '0);
		write_reg(apph_pkg::REG_MAX_PRESSURE, 10'd520);
		send_request(apph_pkg::OP_TICK, 12'ha5a);
	endtask

	task automatic test_setpoint_band;
		drain;
		write_reg(apph_pkg::REG_SETPOINT, 10'd600);
		write_reg(apph_pkg::REG_BAND_PERCENT, 10'd5);
		send_request(apph_pkg::OP_TICK, '0);
		drain;
		// A band above 100 percent drives the lower limit negative; the pump holds.
		write_reg(apph_pkg::REG_SETPOINT, 10'd1023);
		write_reg(apph_pkg::REG_BAND_PERCENT, 10'h3ff);
		send_request(apph_pkg::OP_TICK, '0);
		drain;
		write_reg(REG_UNUSED, 10'h001);
		send_request(apph_pkg::OP_TICK, '0);
		drain;
		write_reg(apph_pkg::REG_SETPOINT, 10'd1);
		write_reg(apph_pkg::REG_BAND_PERCENT, 10'h380);
		send_request(apph_pkg::OP_TICK, '1);
	endtask

	task automatic randomize_config;
		int                          mode;
		logic [apph_pkg::SP_W-1:0]   sp, lo_v, hi_v;
		logic [apph_pkg::BAND_W-1:0] band;
		logic [2:0]                  junk;
		mode = $urandom_range(4);
		sp = '0;
		lo_v = 10'($urandom_range(560));
		hi_v = lo_v + 10'($urandom_range(200));
		band = 7'($urandom_range(127));
		junk = 3'($urandom);
		case (mode)
			0: ;
			1: begin
				lo_v = $urandom_range(1) ? 10'd1023 : 10'd0;
				hi_v = $urandom_range(1) ? 10'd1023 : 10'd0;
			end
			2: begin
				lo_v = 10'($urandom);
				hi_v = 10'($urandom);
			end
			default: begin
				sp = ($urandom_range(7) == 0) ? 10'd1023 : 10'($urandom_range(1, 560));
				case ($urandom_range(5))
					0: band = '0;
					1: band = 7'd127;
					2: band = 7'd100;
					default: ;
				endcase
			end
		endcase
		write_reg(apph_pkg::REG_SETPOINT, sp);
		write_reg(apph_pkg::REG_BAND_PERCENT, {junk, band});
		write_reg(apph_pkg::REG_MIN_PRESSURE, lo_v);
		write_reg(apph_pkg::REG_MAX_PRESSURE, hi_v);
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
		int level, value;
		drain;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		level = 0;
		for (int seg = 0; seg < 5; seg++) begin
			drain;
			randomize_config;
			for (int i = 0; i < n_items / 5; i++) begin
				// Each average centers on one level so the pressure walks across the band.
				if (avg_count == 0) begin
					case ($urandom_range(9))
						0: level = 0;
						1: level = 4095;
						2: level = $urandom_range(120);
						default: level = $urandom_range(4095);
					endcase
				end
				if ($urandom_range(3) == 0) begin
					send_request(apph_pkg::OP_TICK, SAMPLE_W'($urandom));
				end else begin
					value = level + $urandom_range(256) - 128;
					if ($urandom_range(7) == 0)
						value = $urandom_range(4095);
					if (value < 0)
						value = 0;
					if (value > 4095)
						value = 4095;
					send_request(apph_pkg::OP_SAMPLE, SAMPLE_W'(value));
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 33;
		recv_idle_pct = 67;
		test_reset_defaults;
		test_full_scale_average;
		test_plain_limits;
		test_setpoint_band;
		test_random_phase(33, 67, 250);
		test_random_phase(67, 33, 250);
		test_random_phase(0, 0, 250);
		drain;
		if (mismatches == 0)
			$display("averaged_pressure_pump_hysteresis_top: match");
		else
			$display("averaged_pressure_pump_hysteresis_top: mismatch");
		$finish;
	end

endmodule
